// File: rtl/gcm_pkg.sv
// Package for the gamepad command mapper: field widths, register indexes,
// lockout slot numbers, plane codes and the pipeline stage record.
// No dependencies.
`default_nettype none

package gcm_pkg;

  // Field and port widths
  localparam int unsigned AXIS_W      = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned NUM_LOCKS   = 5;
  localparam int unsigned LOCK_IDX_W  = 3;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 56;

  // Input tdata bit positions
  localparam int unsigned IN_BTN_A     = 0;
  localparam int unsigned IN_BTN_B     = 1;
  localparam int unsigned IN_BTN_START = 2;
  localparam int unsigned IN_BTN_LB    = 3;
  localparam int unsigned IN_BTN_RB    = 4;
  localparam int unsigned IN_AXIS_RV   = 5;
  localparam int unsigned IN_AXIS_LH   = 21;
  localparam int unsigned IN_AXIS_LV   = 37;

  // Output tdata bit positions
  localparam int unsigned OUT_VEL_X   = 0;
  localparam int unsigned OUT_VEL_Y   = 16;
  localparam int unsigned OUT_VEL_Z   = 32;
  localparam int unsigned OUT_GRIPPER = 48;
  localparam int unsigned OUT_PLANE   = 49;
  localparam int unsigned OUT_LEARN   = 51;
  localparam int unsigned OUT_REQ     = 52;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_STEP = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] LOCKOUT_TICKS_RST = 16'd400;
  localparam logic [CFG_W-1:0] VELOCITY_STEP_RST = 16'd655;

  // Velocity factor full scale, 1.0 in Q1.15
  localparam logic [AXIS_W-1:0] FACTOR_ONE = 16'h8000;

  // Lockout counter slots
  localparam logic [LOCK_IDX_W-1:0] LOCK_A     = 3'd0;
  localparam logic [LOCK_IDX_W-1:0] LOCK_START = 3'd1;
  localparam logic [LOCK_IDX_W-1:0] LOCK_LB    = 3'd2;
  localparam logic [LOCK_IDX_W-1:0] LOCK_RB    = 3'd3;
  localparam logic [LOCK_IDX_W-1:0] LOCK_B     = 3'd4;

  // Item kind carried in tuser
  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // Motion plane codes
  typedef enum logic [1:0] {
    PLANE_XY = 2'd0,
    PLANE_YZ = 2'd1,
    PLANE_XZ = 2'd2,
    PLANE_NA = 2'd3
  } plane_e;

  // Record handed from the state update stage to the scaling stage
  typedef struct packed {
    logic [AXIS_W-1:0]        factor;
    logic signed [AXIS_W-1:0] axis_rv;
    logic signed [AXIS_W-1:0] axis_lh;
    logic signed [AXIS_W-1:0] axis_lv;
    logic                     gripper;
    plane_e                   plane;
    logic                     learn;
    logic                     req;
  } mid_t;

endpackage : gcm_pkg

`default_nettype wire

// File: rtl/gamepad_command_mapper.sv
// Gamepad command mapper top level: input register, state update stage and
// velocity scaling stage with an output register. Depends on gcm_pkg.
//
// Usage:
//   The slave stream carries items: tuser[0] says tick (0) or sample (1).
//   A tick counts the five button lockouts down and yields no result. A
//   sample yields one result on the master stream with the three stick axes
//   scaled by the velocity factor and the gripper, plane and learning state.
//   Configuration is a plain write port (lockout ticks, velocity step). The
//   user writes it only while the block holds no item; the block does not
//   enforce this. A sample passes the input register, the update register
//   and the output register with the multiply, in that order.
//   Throughput: one item per cycle while the receiver does not stall; the
//   state update stage is a single pass on the state registers, so
//   back-to-back samples see each other's effect.
//   Reset clears all stages, the lockouts, the factor, gripper and learning
//   state, sets the plane to YZ and loads the register defaults.
//   When the receiver stalls, each stage holds its item and s_axis_tready
//   stays high until the input register too is full; ticks keep draining
//   through the update stage as they need no downstream space.
`default_nettype none

module gamepad_command_mapper (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [gcm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [gcm_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Input items
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: button_a, button_b, button_start, button_lb, button_rb,
  //        axis_right_vertical, axis_left_horizontal, axis_left_vertical, pad
  input  wire logic [gcm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: op
  input  wire logic [0:0]                          s_axis_tuser,
  // Result items
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: vel_x, vel_y, vel_z, gripper_closed, motion_plane, learning_on,
  //        learning_request, pad
  output logic [gcm_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

  localparam int unsigned AW = gcm_pkg::AXIS_W;
  localparam int unsigned SW = AW + 2;     // signed factor sum width
  localparam int unsigned PW = 2 * AW + 1; // product width

  // Configuration registers
  logic [gcm_pkg::CFG_W-1:0] lockout_ticks_q, velocity_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_ticks_q <= gcm_pkg::LOCKOUT_TICKS_RST;
      velocity_step_q <= gcm_pkg::VELOCITY_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gcm_pkg::REG_LOCKOUT_TICKS: lockout_ticks_q <= cfg_wdata_i;
        gcm_pkg::REG_VELOCITY_STEP: velocity_step_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake chain
  logic s1_valid_q, mid_valid_q, out_valid_q;
  logic s1_op_q;
  logic [gcm_pkg::IN_TDATA_W-1:0] s1_data_q;
  logic out_ready, mid_ready, s1_adv, s1_sample;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign mid_ready     = !mid_valid_q || out_ready;
  assign s1_sample     = (s1_op_q == gcm_pkg::OP_SAMPLE);
  assign s1_adv        = s1_valid_q && (!s1_sample || mid_ready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_op_q   <= s_axis_tuser[0];
      s1_data_q <= s_axis_tdata;
    end
  end

  // State registers
  logic [gcm_pkg::CFG_W-1:0] lock_q [gcm_pkg::NUM_LOCKS];
  logic [gcm_pkg::CFG_W-1:0] lock_d [gcm_pkg::NUM_LOCKS];
  logic [AW-1:0]             factor_q, factor_d;
  logic                      gripper_q, gripper_d;
  logic                      learn_q, learn_d;
  gcm_pkg::plane_e           plane_q, plane_d;

  logic [gcm_pkg::NUM_LOCKS-1:0] press, acc;
  logic signed [SW-1:0]          f_sum;
  gcm_pkg::mid_t                 mid_d, mid_q;

  // Button decode into lockout slot order
  always_comb begin
    press = '0;
    press[gcm_pkg::LOCK_A]     = s1_data_q[gcm_pkg::IN_BTN_A];
    press[gcm_pkg::LOCK_START] = s1_data_q[gcm_pkg::IN_BTN_START];
    press[gcm_pkg::LOCK_LB]    = s1_data_q[gcm_pkg::IN_BTN_LB];
    press[gcm_pkg::LOCK_RB]    = s1_data_q[gcm_pkg::IN_BTN_RB];
    press[gcm_pkg::LOCK_B]     = s1_data_q[gcm_pkg::IN_BTN_B];
  end

  // Lockouts: ticks count down, accepted presses reload
  always_comb begin
    for (int i = 0; i < gcm_pkg::NUM_LOCKS; i++) begin
      acc[i]    = s1_sample && press[i] && (lock_q[i] == '0);
      lock_d[i] = lock_q[i];
      if (s1_adv) begin
        if (!s1_sample) begin
          if (lock_q[i] != '0) lock_d[i] = lock_q[i] - gcm_pkg::CFG_W'(1);
        end else if (acc[i]) begin
          lock_d[i] = lockout_ticks_q;
        end
      end
    end
  end

  // Toggles, plane cycle and saturating factor step
  always_comb begin
    gripper_d = gripper_q;
    learn_d   = learn_q;
    plane_d   = plane_q;
    factor_d  = factor_q;

    f_sum = $signed({2'b00, factor_q});
    if (acc[gcm_pkg::LOCK_RB]) f_sum = f_sum + $signed({2'b00, velocity_step_q});
    if (acc[gcm_pkg::LOCK_LB]) f_sum = f_sum - $signed({2'b00, velocity_step_q});

    if (s1_adv && s1_sample) begin
      if (acc[gcm_pkg::LOCK_A])     gripper_d = !gripper_q;
      if (acc[gcm_pkg::LOCK_START]) learn_d   = !learn_q;
      if (acc[gcm_pkg::LOCK_B]) begin
        case (plane_q)
          gcm_pkg::PLANE_XY: plane_d = gcm_pkg::PLANE_YZ;
          gcm_pkg::PLANE_YZ: plane_d = gcm_pkg::PLANE_XZ;
          gcm_pkg::PLANE_XZ: plane_d = gcm_pkg::PLANE_XY;
          default:           plane_d = plane_q;
        endcase
      end
      if (f_sum > $signed({2'b00, gcm_pkg::FACTOR_ONE})) begin
        factor_d = gcm_pkg::FACTOR_ONE;
      end else if (f_sum[SW-1]) begin
        factor_d = '0;
      end else begin
        factor_d = f_sum[AW-1:0];
      end
    end

    mid_d.factor  = factor_d;
    mid_d.axis_rv = $signed(s1_data_q[gcm_pkg::IN_AXIS_RV +: AW]);
    mid_d.axis_lh = $signed(s1_data_q[gcm_pkg::IN_AXIS_LH +: AW]);
    mid_d.axis_lv = $signed(s1_data_q[gcm_pkg::IN_AXIS_LV +: AW]);
    mid_d.gripper = gripper_d;
    mid_d.plane   = plane_d;
    mid_d.learn   = learn_d;
    mid_d.req     = acc[gcm_pkg::LOCK_START];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gcm_pkg::NUM_LOCKS; i++) lock_q[i] <= '0;
      factor_q  <= '0;
      gripper_q <= 1'b0;
      learn_q   <= 1'b0;
      plane_q   <= gcm_pkg::PLANE_YZ;
    end else begin
      for (int i = 0; i < gcm_pkg::NUM_LOCKS; i++) lock_q[i] <= lock_d[i];
      factor_q  <= factor_d;
      gripper_q <= gripper_d;
      learn_q   <= learn_d;
      plane_q   <= plane_d;
    end
  end

  // Update stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (mid_ready) begin
      mid_valid_q <= s1_adv && s1_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_ready && s1_adv && s1_sample) mid_q <= mid_d;
  end

  // Scaling stage: floor(factor * axis / 2^15)
  logic signed [PW-1:0] prod_x, prod_y, prod_z;
  logic [gcm_pkg::OUT_TDATA_W-1:0] out_d, out_data_q;

  always_comb begin
    prod_x = $signed({1'b0, mid_q.factor}) * mid_q.axis_rv;
    prod_y = $signed({1'b0, mid_q.factor}) * mid_q.axis_lh;
    prod_z = $signed({1'b0, mid_q.factor}) * mid_q.axis_lv;
    out_d = '0;
    out_d[gcm_pkg::OUT_VEL_X +: AW] = prod_x[AW+AW-2:AW-1];
    out_d[gcm_pkg::OUT_VEL_Y +: AW] = prod_y[AW+AW-2:AW-1];
    out_d[gcm_pkg::OUT_VEL_Z +: AW] = prod_z[AW+AW-2:AW-1];
    out_d[gcm_pkg::OUT_GRIPPER]     = mid_q.gripper;
    out_d[gcm_pkg::OUT_PLANE +: 2]  = mid_q.plane;
    out_d[gcm_pkg::OUT_LEARN]       = mid_q.learn;
    out_d[gcm_pkg::OUT_REQ]         = mid_q.req;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && mid_valid_q) out_data_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule : gamepad_command_mapper

`default_nettype wire

// File: rtl/gcm_checker.sv
// Port-level checker for the gamepad command mapper, bound to the top level.
// Depends on gcm_pkg and gamepad_command_mapper.
`default_nettype none

module gcm_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [gcm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  // Learning state of the last delivered item
  logic prev_learn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_learn_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      prev_learn_q <= m_axis_tdata[gcm_pkg::OUT_LEARN];
    end
  end

  // No result shown while in reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // A stalled item holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled item changed");

  // Plane never leaves the three valid codes
  a_plane_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[gcm_pkg::OUT_PLANE +: 2] != gcm_pkg::PLANE_NA))
    else $error("motion plane code out of range");

  // Learning request flags exactly the items where learning mode flipped
  a_learn_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[gcm_pkg::OUT_REQ] ==
                       (m_axis_tdata[gcm_pkg::OUT_LEARN] != prev_learn_q)))
    else $error("learning request does not match learning toggle");

  // With the output side empty every stage can drain, so input is taken
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule : gcm_checker

bind gamepad_command_mapper gcm_checker u_gcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
